// File: hw/rtl/ped_pkg.sv
// Shared types, constants and register reset values for the pedometer step detector.
// No dependencies; every other file in hw/rtl imports this package.
package ped_pkg;

    // Field widths
    localparam int COUNT_BITS     = 32;
    localparam int ACCEL_BITS     = 16;
    localparam int TIME_BITS      = 32;
    localparam int ALPHA_BITS     = 16;
    localparam int LEVEL_BITS     = 15;
    localparam int GAP_BITS       = 16;
    localparam int MAG_BITS       = 16;
    localparam int OUT_COUNT_BITS = 32;
    localparam int OPCODE_BITS    = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    // Square root and multiplier sizing
    localparam int SUM_W       = 2 * ACCEL_BITS + 2;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int REM_W       = ROOT_W + 1;
    localparam int SQRT_CNT_W  = $clog2(ROOT_W);
    localparam int ROOT_EXT_W  = (ROOT_W > MAG_BITS) ? ROOT_W : MAG_BITS + 1;
    localparam int MUL_W       = (ACCEL_BITS + 1 > MAG_BITS + 2) ? ACCEL_BITS + 1 : MAG_BITS + 2;
    localparam int PROD_W      = 2 * MUL_W;

    // Input opcodes
    typedef logic [OPCODE_BITS-1:0] opcode_t;
    localparam opcode_t OP_SAMPLE    = 2'd0;
    localparam opcode_t OP_RST_TODAY = 2'd1;
    localparam opcode_t OP_RST_BOTH  = 2'd2;

    // Configuration register indexes
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    localparam cfg_index_t CFG_FAST_ALPHA   = 3'd0;
    localparam cfg_index_t CFG_SLOW_ALPHA   = 3'd1;
    localparam cfg_index_t CFG_PEAK_LEVEL   = 3'd2;
    localparam cfg_index_t CFG_VALLEY_LEVEL = 3'd3;
    localparam cfg_index_t CFG_MIN_STEP_GAP = 3'd4;
    localparam cfg_index_t CFG_SAMPLE_GAP   = 3'd5;
    localparam cfg_index_t CFG_DAY_LENGTH   = 3'd6;

    // Register reset values
    localparam logic [ALPHA_BITS-1:0] FAST_ALPHA_RST   = 16'd19661;
    localparam logic [ALPHA_BITS-1:0] SLOW_ALPHA_RST   = 16'd1311;
    localparam logic [LEVEL_BITS-1:0] PEAK_LEVEL_RST   = 15'd573;
    localparam logic [LEVEL_BITS-1:0] VALLEY_LEVEL_RST = 15'd205;
    localparam logic [GAP_BITS-1:0]   MIN_STEP_GAP_RST = 16'd250;
    localparam logic [GAP_BITS-1:0]   SAMPLE_GAP_RST   = 16'd20;
    localparam logic [TIME_BITS-1:0]  DAY_LENGTH_RST   = 32'd86400000;

    localparam logic [MAG_BITS-1:0] MAG_MAX = {MAG_BITS{1'b1}};

    typedef struct packed {
        logic [OPCODE_BITS-1:0]       opcode;
        logic [TIME_BITS-1:0]         now_ms;
        logic signed [ACCEL_BITS-1:0] accel_x;
        logic signed [ACCEL_BITS-1:0] accel_y;
        logic signed [ACCEL_BITS-1:0] accel_z;
    } ped_in_t;

    typedef struct packed {
        logic                      sample_used;
        logic                      step_counted;
        logic                      day_rolled;
        logic [OUT_COUNT_BITS-1:0] today_count;
        logic [OUT_COUNT_BITS-1:0] total_count;
    } ped_out_t;

    typedef struct packed {
        logic [ALPHA_BITS-1:0] fast_alpha;
        logic [ALPHA_BITS-1:0] slow_alpha;
        logic [LEVEL_BITS-1:0] peak_level;
        logic [LEVEL_BITS-1:0] valley_level;
        logic [GAP_BITS-1:0]   min_step_gap_ms;
        logic [GAP_BITS-1:0]   sample_gap_ms;
        logic [TIME_BITS-1:0]  day_length_ms;
    } ped_cfg_t;

    // Datapath operations, one per cycle
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SQ_X,
        DP_SQ_Y,
        DP_SQ_Z,
        DP_SQ_SUM,
        DP_SQRT_STEP,
        DP_FAST_MUL,
        DP_FAST_UPD,
        DP_SLOW_MUL,
        DP_SLOW_UPD,
        DP_DETECT,
        DP_DAY,
        DP_RST_TODAY,
        DP_RST_BOTH,
        DP_RESULT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_SUM,
        ST_SQRT,
        ST_FAST_MUL,
        ST_FAST_UPD,
        ST_SLOW_MUL,
        ST_SLOW_UPD,
        ST_DETECT,
        ST_DAY,
        ST_RST_TODAY,
        ST_RST_BOTH,
        ST_DONE
    } ped_state_t;

    typedef struct packed {
        dp_op_t op;
    } ped_cmd_t;

    typedef struct packed {
        opcode_t opcode;
        logic    gate_ok;
        logic    sqrt_last;
    } ped_status_t;

endpackage

// File: hw/rtl/ped_cfg_regs.sv
// Configuration register file of the pedometer step detector.
// Depends on ped_pkg for the register indexes, reset values and ped_cfg_t.
module ped_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ped_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ped_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output ped_pkg::ped_cfg_t                   cfg
);
    import ped_pkg::*;

    ped_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Write the addressed register on each config beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_alpha      <= FAST_ALPHA_RST;
            cfg_reg.slow_alpha      <= SLOW_ALPHA_RST;
            cfg_reg.peak_level      <= PEAK_LEVEL_RST;
            cfg_reg.valley_level    <= VALLEY_LEVEL_RST;
            cfg_reg.min_step_gap_ms <= MIN_STEP_GAP_RST;
            cfg_reg.sample_gap_ms   <= SAMPLE_GAP_RST;
            cfg_reg.day_length_ms   <= DAY_LENGTH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FAST_ALPHA:   cfg_reg.fast_alpha      <= cfg_data[ALPHA_BITS-1:0];
                CFG_SLOW_ALPHA:   cfg_reg.slow_alpha      <= cfg_data[ALPHA_BITS-1:0];
                CFG_PEAK_LEVEL:   cfg_reg.peak_level      <= cfg_data[LEVEL_BITS-1:0];
                CFG_VALLEY_LEVEL: cfg_reg.valley_level    <= cfg_data[LEVEL_BITS-1:0];
                CFG_MIN_STEP_GAP: cfg_reg.min_step_gap_ms <= cfg_data[GAP_BITS-1:0];
                CFG_SAMPLE_GAP:   cfg_reg.sample_gap_ms   <= cfg_data[GAP_BITS-1:0];
                CFG_DAY_LENGTH:   cfg_reg.day_length_ms   <= cfg_data[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: hw/rtl/ped_ctrl.sv
// Step detector controller: one datapath operation a cycle unless stalled in ST_DONE.
// Depends on ped_pkg for the state, command and status types.
module ped_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  ped_pkg::ped_status_t  status,
    output ped_pkg::ped_cmd_t     cmd
);
    import ped_pkg::*;

    ped_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and datapath command
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd.op       = DP_NOP;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                unique case (status.opcode)
                    OP_SAMPLE:    state_next = status.gate_ok ? ST_SQ_X : ST_DONE;
                    OP_RST_TODAY: state_next = ST_RST_TODAY;
                    OP_RST_BOTH:  state_next = ST_RST_BOTH;
                    default:      state_next = ST_DONE;
                endcase
            end
            ST_SQ_X: begin
                cmd.op     = DP_SQ_X;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                cmd.op     = DP_SQ_Y;
                state_next = ST_SQ_Z;
            end
            ST_SQ_Z: begin
                cmd.op     = DP_SQ_Z;
                state_next = ST_SQ_SUM;
            end
            ST_SQ_SUM: begin
                cmd.op     = DP_SQ_SUM;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.op = DP_SQRT_STEP;
                if (status.sqrt_last) begin
                    state_next = ST_FAST_MUL;
                end
            end
            ST_FAST_MUL: begin
                cmd.op     = DP_FAST_MUL;
                state_next = ST_FAST_UPD;
            end
            ST_FAST_UPD: begin
                cmd.op     = DP_FAST_UPD;
                state_next = ST_SLOW_MUL;
            end
            ST_SLOW_MUL: begin
                cmd.op     = DP_SLOW_MUL;
                state_next = ST_SLOW_UPD;
            end
            ST_SLOW_UPD: begin
                cmd.op     = DP_SLOW_UPD;
                state_next = ST_DETECT;
            end
            ST_DETECT: begin
                cmd.op     = DP_DETECT;
                state_next = ST_DAY;
            end
            ST_DAY: begin
                cmd.op     = DP_DAY;
                state_next = ST_DONE;
            end
            ST_RST_TODAY: begin
                cmd.op     = DP_RST_TODAY;
                state_next = ST_DONE;
            end
            ST_RST_BOTH: begin
                cmd.op     = DP_RST_BOTH;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = DP_RESULT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/ped_datapath.sv
// Datapath of the pedometer step detector: squares, iterative square root, averages,
// peak/valley detection, day window and counters. Depends on ped_pkg.
module ped_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ped_pkg::ped_cfg_t     cfg,
    input  ped_pkg::ped_cmd_t     cmd,
    input  ped_pkg::ped_in_t      s_data,
    output ped_pkg::ped_status_t  status,
    output ped_pkg::ped_out_t     m_data
);
    import ped_pkg::*;

    // Item and working registers
    ped_in_t                   in_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [SUM_W-1:0]          rad_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [SQRT_CNT_W-1:0]     sqrt_cnt_reg;
    logic                      used_reg;
    logic                      step_reg;
    logic                      roll_reg;
    ped_out_t                  out_reg;

    // Detector state
    logic [MAG_BITS-1:0]       fast_reg;
    logic [MAG_BITS-1:0]       slow_reg;
    logic                      armed_reg;
    logic [TIME_BITS-1:0]      last_sample_reg;
    logic [TIME_BITS-1:0]      last_step_reg;
    logic [TIME_BITS-1:0]      day_start_reg;
    logic [COUNT_BITS-1:0]     total_reg;
    logic [COUNT_BITS-1:0]     today_reg;

    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   mul_prod;
    logic [ROOT_W+2:0]          sqrt_cand;
    logic [ROOT_W+2:0]          sqrt_trial;
    logic [ROOT_W+2:0]          sqrt_diff;
    logic                       sqrt_take;
    logic [ROOT_EXT_W-1:0]      root_ext;
    logic [MAG_BITS-1:0]        mag;
    logic signed [MAG_BITS:0]   fast_diff;
    logic signed [MAG_BITS:0]   slow_diff;
    logic signed [PROD_W-1:0]   fast_sum;
    logic signed [PROD_W-1:0]   slow_sum;
    logic signed [MAG_BITS:0]   dev;
    logic [TIME_BITS-1:0]       now;
    logic [TIME_BITS-1:0]       day_eff;
    logic                       arm_now;
    logic                       step_now;
    logic                       roll_now;

    assign now = in_reg.now_ms;

    // Status back to the controller
    assign status.opcode    = in_reg.opcode;
    assign status.gate_ok   = (now - last_sample_reg) >= TIME_BITS'(cfg.sample_gap_ms);
    assign status.sqrt_last = (sqrt_cnt_reg == '0);

    // Saturate the root to the magnitude width
    assign root_ext = ROOT_EXT_W'(root_reg);
    assign mag      = (root_ext > ROOT_EXT_W'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_BITS-1:0];

    assign fast_diff = $signed({1'b0, mag}) - $signed({1'b0, fast_reg});
    assign slow_diff = $signed({1'b0, fast_reg}) - $signed({1'b0, slow_reg});
    assign dev       = slow_diff;

    // Shared multiplier: squares, then the two blend products
    always_comb begin
        case (cmd.op)
            DP_SQ_X: begin
                mul_a = MUL_W'(in_reg.accel_x);
                mul_b = MUL_W'(in_reg.accel_x);
            end
            DP_SQ_Y: begin
                mul_a = MUL_W'(in_reg.accel_y);
                mul_b = MUL_W'(in_reg.accel_y);
            end
            DP_SQ_Z: begin
                mul_a = MUL_W'(in_reg.accel_z);
                mul_b = MUL_W'(in_reg.accel_z);
            end
            DP_FAST_MUL: begin
                mul_a = MUL_W'({1'b0, cfg.fast_alpha});
                mul_b = MUL_W'(fast_diff);
            end
            DP_SLOW_MUL: begin
                mul_a = MUL_W'({1'b0, cfg.slow_alpha});
                mul_b = MUL_W'(slow_diff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // Blend: old + alpha*(new - old), scaled by 2^16
    assign fast_sum = $signed(PROD_W'({fast_reg, {ALPHA_BITS{1'b0}}})) + prod_reg;
    assign slow_sum = $signed(PROD_W'({slow_reg, {ALPHA_BITS{1'b0}}})) + prod_reg;

    // One root bit per step from the top two radicand bits
    assign sqrt_cand  = {rem_reg, rad_reg[SUM_W-1 -: 2]};
    assign sqrt_trial = {1'b0, root_reg, 2'b01};
    assign sqrt_diff  = sqrt_cand - sqrt_trial;
    assign sqrt_take  = (sqrt_cand >= sqrt_trial);

    // Peak arming, step counting and day rollover decisions
    assign arm_now  = !armed_reg && (dev > $signed({2'b00, cfg.peak_level}))
                      && ((now - last_step_reg) >= TIME_BITS'(cfg.min_step_gap_ms));
    assign step_now = armed_reg && (dev < $signed({2'b00, cfg.valley_level}));
    assign day_eff  = (day_start_reg == '0) ? now : day_start_reg;
    assign roll_now = (now - day_eff) >= cfg.day_length_ms;

    // Working registers and result flags
    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_LOAD: begin
                in_reg   <= s_data;
                used_reg <= 1'b0;
                step_reg <= 1'b0;
                roll_reg <= 1'b0;
            end
            DP_SQ_X: begin
                prod_reg <= mul_prod;
                used_reg <= 1'b1;
            end
            DP_SQ_Y: begin
                sum_reg  <= SUM_W'(prod_reg);
                prod_reg <= mul_prod;
            end
            DP_SQ_Z: begin
                sum_reg  <= sum_reg + SUM_W'(prod_reg);
                prod_reg <= mul_prod;
            end
            DP_SQ_SUM: begin
                rad_reg      <= sum_reg + SUM_W'(prod_reg);
                rem_reg      <= '0;
                root_reg     <= '0;
                sqrt_cnt_reg <= SQRT_CNT_W'(ROOT_W - 1);
            end
            DP_SQRT_STEP: begin
                rad_reg      <= rad_reg << 2;
                sqrt_cnt_reg <= sqrt_cnt_reg - SQRT_CNT_W'(1);
                if (sqrt_take) begin
                    rem_reg  <= sqrt_diff[REM_W-1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= sqrt_cand[REM_W-1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            DP_FAST_MUL, DP_SLOW_MUL: begin
                prod_reg <= mul_prod;
            end
            DP_DETECT: begin
                step_reg <= step_now;
            end
            DP_DAY: begin
                roll_reg <= roll_now;
            end
            DP_RESULT: begin
                out_reg.sample_used  <= used_reg;
                out_reg.step_counted <= step_reg;
                out_reg.day_rolled   <= roll_reg;
                out_reg.today_count  <= OUT_COUNT_BITS'(today_reg);
                out_reg.total_count  <= OUT_COUNT_BITS'(total_reg);
            end
            default: ;
        endcase
    end

    // Detector state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_reg        <= '0;
            slow_reg        <= '0;
            armed_reg       <= 1'b0;
            last_sample_reg <= '0;
            last_step_reg   <= '0;
            day_start_reg   <= '0;
            total_reg       <= '0;
            today_reg       <= '0;
        end else begin
            case (cmd.op)
                DP_SQ_X: begin
                    last_sample_reg <= now;
                end
                DP_FAST_UPD: begin
                    fast_reg <= fast_sum[ALPHA_BITS+MAG_BITS-1:ALPHA_BITS];
                end
                DP_SLOW_UPD: begin
                    slow_reg <= slow_sum[ALPHA_BITS+MAG_BITS-1:ALPHA_BITS];
                end
                DP_DETECT: begin
                    if (arm_now) begin
                        armed_reg <= 1'b1;
                    end else if (step_now) begin
                        armed_reg     <= 1'b0;
                        total_reg     <= total_reg + COUNT_BITS'(1);
                        today_reg     <= today_reg + COUNT_BITS'(1);
                        last_step_reg <= now;
                    end
                end
                DP_DAY: begin
                    if (roll_now) begin
                        today_reg     <= '0;
                        day_start_reg <= now;
                    end else begin
                        day_start_reg <= day_eff;
                    end
                end
                DP_RST_TODAY: begin
                    today_reg     <= '0;
                    day_start_reg <= now;
                end
                DP_RST_BOTH: begin
                    today_reg     <= '0;
                    total_reg     <= '0;
                    day_start_reg <= now;
                end
                default: ;
            endcase
        end
    end

    assign m_data = out_reg;

endmodule

// File: hw/rtl/pedometer_step_detector_top.sv
// Pedometer step detector, peak/valley scheme in Q4.12 fixed point.
// A used sample passes the gate check, squares and sum, square root steps, average,
// detect and day steps and the output step; the next item is taken only once the last
// result is in the output register. A skipped sample or unused opcode goes from the gate
// check to the output step, a reset event via its reset step. The output register holds a
// result while the next item is accepted. Synchronous active-low reset restores defaults.
module pedometer_step_detector_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ped_pkg::ped_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ped_pkg::ped_out_t                   m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ped_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ped_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import ped_pkg::*;

    ped_cfg_t    cfg;
    ped_cmd_t    cmd;
    ped_status_t status;

    ped_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ped_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ped_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .s_data  (s_data),
        .status  (status),
        .m_data  (m_data)
    );

endmodule

// File: tb/ped_checker.sv
`timescale 1ns / 1ps
// Result checker for the pedometer step detector: watches sample, result and register beats.
// Keeps its own copy of the detector state and settings; depends on ped_pkg only.
module ped_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  ped_pkg::ped_in_t                    s_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  ped_pkg::ped_out_t                   m_data,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [ped_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ped_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output int                                  fail_count,
    output int                                  outstanding,
    output int                                  checked_count,
    output int                                  step_count,
    output int                                  roll_count
);
    import ped_pkg::*;

    // Tracked settings and detector state
    ped_cfg_t                settings;
    logic [MAG_BITS-1:0]     fast_avg;
    logic [MAG_BITS-1:0]     base_avg;
    logic                    armed;
    logic [TIME_BITS-1:0]    last_used_ms;
    logic [TIME_BITS-1:0]    last_step_ms;
    logic [TIME_BITS-1:0]    day_origin_ms;
    logic [COUNT_BITS-1:0]   total_steps;
    logic [COUNT_BITS-1:0]   today_steps;

    ped_out_t pending_results[$];
    int       fails;
    int       checked;
    int       steps;
    int       rolls;

    // Floor of the square root, one bit per pass from the top
    function automatic logic [17:0] root_floor(input logic [35:0] v);
        logic [17:0] r;
        logic [17:0] c;
        r = '0;
        for (int b = 17; b >= 0; b--) begin
            c = r | (18'd1 << b);
            if (36'(c) * 36'(c) <= v) begin
                r = c;
            end
        end
        return r;
    endfunction

    // Exponential average in Q0.16 weight, truncated
    function automatic logic [15:0] ema(input logic [15:0] w, input logic [15:0] x,
                                        input logic [15:0] prev);
        logic [63:0] acc;
        acc = 64'(w) * 64'(x) + (64'd65536 - 64'(w)) * 64'(prev);
        return acc[31:16];
    endfunction

    // Advance the tracked state by one input beat and build the result it causes
    task automatic track_item(input ped_in_t it, output ped_out_t res);
        longint           ax;
        longint           ay;
        longint           az;
        logic [35:0]      sq_sum;
        logic [17:0]      root;
        logic [15:0]      mag;
        int               dev;
        logic [31:0]      now;
        now = it.now_ms;
        res = '0;
        case (it.opcode)
            OP_SAMPLE: begin
                if (32'(now - last_used_ms) >= 32'(settings.sample_gap_ms)) begin
                    ax = $signed(it.accel_x);
                    ay = $signed(it.accel_y);
                    az = $signed(it.accel_z);
                    sq_sum = 36'(ax * ax + ay * ay + az * az);
                    root = root_floor(sq_sum);
                    mag = (root > 18'(MAG_MAX)) ? MAG_MAX : root[15:0];
                    res.sample_used = 1'b1;
                    last_used_ms = now;
                    fast_avg = ema(settings.fast_alpha, mag, fast_avg);
                    base_avg = ema(settings.slow_alpha, fast_avg, base_avg);
                    dev = int'(fast_avg) - int'(base_avg);

                    // Arm on a rise past the peak level, count on the fall below the valley
                    if (!armed) begin
                        if (dev > int'(settings.peak_level) &&
                            32'(now - last_step_ms) >= 32'(settings.min_step_gap_ms)) begin
                            armed = 1'b1;
                        end
                    end else if (dev < int'(settings.valley_level)) begin
                        armed = 1'b0;
                        total_steps = total_steps + 1'b1;
                        today_steps = today_steps + 1'b1;
                        last_step_ms = now;
                        res.step_counted = 1'b1;
                    end

                    // Start the day window if unset, roll it once it has run out
                    if (day_origin_ms == '0) begin
                        day_origin_ms = now;
                    end
                    if (32'(now - day_origin_ms) >= settings.day_length_ms) begin
                        today_steps = '0;
                        day_origin_ms = now;
                        res.day_rolled = 1'b1;
                    end
                end
            end
            OP_RST_TODAY: begin
                today_steps = '0;
                day_origin_ms = now;
            end
            OP_RST_BOTH: begin
                today_steps = '0;
                total_steps = '0;
                day_origin_ms = now;
            end
            default: begin
            end
        endcase
        res.today_count = today_steps;
        res.total_count = total_steps;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    // Track register writes and sample beats, then check each result beat in order
    always @(posedge aclk) begin
        ped_out_t want;
        if (!aresetn) begin
            settings = '{fast_alpha: FAST_ALPHA_RST, slow_alpha: SLOW_ALPHA_RST,
                         peak_level: PEAK_LEVEL_RST, valley_level: VALLEY_LEVEL_RST,
                         min_step_gap_ms: MIN_STEP_GAP_RST, sample_gap_ms: SAMPLE_GAP_RST,
                         day_length_ms: DAY_LENGTH_RST};
            fast_avg = '0;
            base_avg = '0;
            armed = 1'b0;
            last_used_ms = '0;
            last_step_ms = '0;
            day_origin_ms = '0;
            total_steps = '0;
            today_steps = '0;
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FAST_ALPHA:   settings.fast_alpha = cfg_data[ALPHA_BITS-1:0];
                    CFG_SLOW_ALPHA:   settings.slow_alpha = cfg_data[ALPHA_BITS-1:0];
                    CFG_PEAK_LEVEL:   settings.peak_level = cfg_data[LEVEL_BITS-1:0];
                    CFG_VALLEY_LEVEL: settings.valley_level = cfg_data[LEVEL_BITS-1:0];
                    CFG_MIN_STEP_GAP: settings.min_step_gap_ms = cfg_data[GAP_BITS-1:0];
                    CFG_SAMPLE_GAP:   settings.sample_gap_ms = cfg_data[GAP_BITS-1:0];
                    CFG_DAY_LENGTH:   settings.day_length_ms = cfg_data[TIME_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                track_item(s_data, want);
                pending_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual today %0d total %0d",
                             $time, m_data.today_count, m_data.total_count);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("sample_used", 32'(want.sample_used), 32'(m_data.sample_used));
                    compare_field("step_counted", 32'(want.step_counted),
                                  32'(m_data.step_counted));
                    compare_field("day_rolled", 32'(want.day_rolled), 32'(m_data.day_rolled));
                    compare_field("today_count", want.today_count, m_data.today_count);
                    compare_field("total_count", want.total_count, m_data.total_count);
                    checked++;
                    if (want.step_counted) begin
                        steps++;
                    end
                    if (want.day_rolled) begin
                        rolls++;
                    end
                end
            end
        end
        fail_count <= fails;
        outstanding <= pending_results.size();
        checked_count <= checked;
        step_count <= steps;
        roll_count <= rolls;
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the pedometer step detector testbench: clock, reset, stimulus and verdict.
// Depends on ped_pkg, pedometer_step_detector_top and ped_checker.
module tb_top;
    import ped_pkg::*;

    localparam opcode_t OP_SPARE    = 2'd3;
    localparam int      STALL_LIMIT = 3000;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    ped_in_t           s_data;
    logic              m_valid;
    logic              m_ready;
    ped_out_t          m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    cfg_index_t        cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    int fail_count;
    int outstanding;
    int checked_count;
    int step_count;
    int roll_count;

    bit       quiet = 1'b0;
    int       sent = 0;
    int       idle_cycles = 0;
    ped_cfg_t cur_cfg;

    pedometer_step_detector_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ped_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count),
        .step_count    (step_count),
        .roll_count    (roll_count)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // End the run when no channel has moved a beat for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // Result side: stall a random number of cycles once a result is showing
    initial begin : result_sink
        int hold;
        m_ready = 1'b0;
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 17);
            if (hold == 0) begin
                if (!m_ready) begin
                    m_ready <= 1'b1;
                end
            end else begin
                m_ready <= 1'b0;
                do @(posedge aclk); while (!m_valid);
                repeat (hold - 1) @(posedge aclk);
                m_ready <= 1'b1;
            end
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic ped_in_t make_item(input opcode_t op, input logic [31:0] t,
                                          input int x, input int y, input int z);
        ped_in_t it;
        it.opcode = op;
        it.now_ms = t;
        it.accel_x = 16'(x);
        it.accel_y = 16'(y);
        it.accel_z = 16'(z);
        return it;
    endfunction

    // Hold off a random gap, then offer one beat until it is taken
    task automatic send_item(input ped_in_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // Drop valid, wait for every expected result, then let the block settle
    task automatic settle(input int extra);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_config(input ped_cfg_t c);
        settle(4);
        cfg_write(CFG_FAST_ALPHA, 32'(c.fast_alpha));
        cfg_write(CFG_SLOW_ALPHA, 32'(c.slow_alpha));
        cfg_write(CFG_PEAK_LEVEL, 32'(c.peak_level));
        cfg_write(CFG_VALLEY_LEVEL, 32'(c.valley_level));
        cfg_write(CFG_MIN_STEP_GAP, 32'(c.min_step_gap_ms));
        cfg_write(CFG_SAMPLE_GAP, 32'(c.sample_gap_ms));
        cfg_write(CFG_DAY_LENGTH, c.day_length_ms);
        cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    initial begin : stimulus
        int          p;
        int          k;
        int          n;
        int          r;
        int          half_len;
        int          amp;
        int          wave_pos;
        int          n_settings;
        logic        high;
        logic [31:0] t_now;
        ped_in_t     it;
        ped_cfg_t    c;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FAST_ALPHA;
        cfg_data = '0;
        half_len = 8;
        amp = 2000;
        wave_pos = 0;
        n_settings = 1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, early sample, every opcode, unset day, wrap, rollover
        send_item(make_item(OP_SAMPLE, 32'd1000, 0, 0, 0));
        send_item(make_item(OP_SAMPLE, 32'd1020, 32767, 32767, 32767));
        send_item(make_item(OP_SAMPLE, 32'd1040, -32768, -32768, -32768));
        send_item(make_item(OP_SAMPLE, 32'd1050, 100, 100, 100));
        send_item(make_item(OP_SAMPLE, 32'd1060, 32767, -32768, 0));
        send_item(make_item(OP_SAMPLE, 32'd1080, 0, 0, 4096));
        for (k = 0; k < 12; k++) begin
            send_item(make_item(OP_SAMPLE, 32'(1400 + 300 * k), 0, 0,
                                ((k / 3) % 2 == 0) ? 12000 : 1000));
        end
        send_item(make_item(OP_RST_TODAY, 32'd5000, 0, 0, 0));
        send_item(make_item(OP_RST_BOTH, 32'd5100, 0, 0, 0));
        send_item(make_item(OP_SPARE, 32'd5200, -1, 1, -1));
        send_item(make_item(OP_RST_TODAY, 32'd0, 0, 0, 0));
        send_item(make_item(OP_SAMPLE, 32'hFFFF_FFF0, 0, 4096, 0));
        send_item(make_item(OP_SAMPLE, 32'h0000_0010, 0, 0, -4096));
        send_item(make_item(OP_SAMPLE, 32'h0600_0000, 4096, 0, 0));
        t_now = 32'h0600_0100;

        // Random phases, each under its own register setting
        for (p = 0; p < 8; p++) begin
            case (p)
                0: c = '{fast_alpha: FAST_ALPHA_RST, slow_alpha: SLOW_ALPHA_RST,
                         peak_level: PEAK_LEVEL_RST, valley_level: VALLEY_LEVEL_RST,
                         min_step_gap_ms: MIN_STEP_GAP_RST, sample_gap_ms: SAMPLE_GAP_RST,
                         day_length_ms: DAY_LENGTH_RST};
                1: c = '{fast_alpha: 16'hFFFF, slow_alpha: 16'd655, peak_level: 15'd0,
                         valley_level: 15'h7FFF, min_step_gap_ms: 16'd0,
                         sample_gap_ms: 16'd0, day_length_ms: 32'd1};
                2: c = '{fast_alpha: 16'd0, slow_alpha: 16'hFFFF, peak_level: 15'h7FFF,
                         valley_level: 15'd0, min_step_gap_ms: 16'hFFFF,
                         sample_gap_ms: 16'hFFFF, day_length_ms: 32'hFFFF_FFFF};
                default: begin
                    c.fast_alpha = 16'($urandom_range(8000, 40000));
                    c.slow_alpha = 16'($urandom_range(300, 4000));
                    c.peak_level = 15'($urandom_range(150, 1500));
                    c.valley_level = 15'($urandom_range(0, c.peak_level));
                    c.min_step_gap_ms = 16'($urandom_range(0, 400));
                    c.sample_gap_ms = 16'($urandom_range(0, 40));
                    c.day_length_ms = $urandom_range(2000, 60000);
                end
            endcase
            apply_config(c);
            n_settings++;
            if (p == 3) begin
                t_now = 32'hFFFF_0000;
            end
            n = (p == 0) ? 350 : (p == 1) ? 150 : (p == 2) ? 100 : 245;

            for (k = 0; k < n; k++) begin
                // New walking rhythm and idling mode every fifty beats
                if (k % 50 == 0) begin
                    quiet = ($urandom_range(0, 3) == 0);
                    half_len = $urandom_range(4, 15);
                    amp = $urandom_range(300, 7000);
                end
                r = $urandom_range(0, 99);
                it = make_item(OP_SAMPLE, t_now, int'($urandom_range(0, 600)) - 300,
                               int'($urandom_range(0, 600)) - 300, 4096);
                if (r < 80) begin
                    // Well-formed walking sample on the square wave
                    t_now += 32'(cur_cfg.sample_gap_ms) + $urandom_range(0, 4);
                    high = (wave_pos % (2 * half_len)) < half_len;
                    wave_pos++;
                    it.now_ms = t_now;
                    it.accel_z = 16'(4096 + (high ? amp : -amp)
                                     + int'($urandom_range(0, 400)) - 200);
                end else if (r < 88) begin
                    // Sample inside the gap
                    if (cur_cfg.sample_gap_ms != 0) begin
                        t_now += $urandom_range(0, cur_cfg.sample_gap_ms - 1);
                    end
                    it.now_ms = t_now;
                end else if (r < 91) begin
                    t_now += $urandom;
                    it.now_ms = t_now;
                end else if (r < 95) begin
                    t_now += $urandom_range(0, 50);
                    it.opcode = (r < 93) ? OP_RST_TODAY : OP_RST_BOTH;
                    it.now_ms = t_now;
                end else begin
                    // Noise: spare opcode or a sample with every field random
                    it.opcode = (r < 97) ? OP_SPARE : OP_SAMPLE;
                    it.now_ms = $urandom;
                    it.accel_x = 16'($urandom);
                    it.accel_y = 16'($urandom);
                    it.accel_z = 16'($urandom);
                end
                send_item(it);
            end
        end

        settle(40);
        $display("tb_top: %0d items under %0d register settings, %0d results checked",
                 sent, n_settings, checked_count);
        $display("tb_top: %0d steps and %0d day rollovers seen in the results",
                 step_count, roll_count);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
